>>> sv/btop_pkg.sv
// btop_pkg: shared types, constants and arithmetic helpers for the binomial pricer
// used by btop_dp, btop_ctrl and binomial_tree_option_pricer; no dependencies
`default_nettype none

package btop_pkg;

    localparam int PRICE_W  = 32;
    localparam int FRAC     = 30;
    localparam int FACTOR_W = 32;
    localparam int PROD_W   = 64;

    localparam logic [30:0] ONE_FACTOR = 31'h4000_0000;

    // configuration register indexes (word address)
    localparam logic [2:0] REG_UP_FACTOR   = 3'd0;
    localparam logic [2:0] REG_DOWN_FACTOR = 3'd1;
    localparam logic [2:0] REG_UP_PROB     = 3'd2;
    localparam logic [2:0] REG_STEP_DISC   = 3'd3;
    localparam logic [2:0] REG_STEPS       = 3'd4;
    localparam logic [2:0] REG_IS_PUT      = 3'd5;
    localparam logic [2:0] REG_IS_AMERICAN = 3'd6;

    // multiplier operand selection
    typedef enum logic [2:0] {
        MS_P_D      = 3'd0,
        MS_P_U      = 3'd1,
        MS_Q_VHI    = 3'd2,
        MS_NQ_VLO   = 3'd3,
        MS_MIX_DISC = 3'd4,
        MS_PR_U     = 3'd5
    } mul_sel_t;

    // command word from controller to datapath
    typedef struct packed {
        logic     load;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     acc_en;
        logic     mix_en;
        logic     hold_en;
        logic     p_upd;
        logic     leaf_wr;
        logic     node_wr;
        logic     vlo_ld;
        logic     vhi_ld;
        logic     res_ld;
    } dp_cmd_t;

    // drop fraction bits, clip at the price maximum; msb is the clip flag
    function automatic logic [PRICE_W:0] sat_shift(input logic [PROD_W-1:0] w);
        logic [PRICE_W:0] r;
        if (w[PROD_W-1:FRAC+PRICE_W] != '0) begin
            r = {1'b1, {PRICE_W{1'b1}}};
        end else begin
            r = {1'b0, w[FRAC+PRICE_W-1:FRAC]};
        end
        return r;
    endfunction

    // call or put payoff, floored at zero
    function automatic logic [PRICE_W-1:0] payoff(input logic [PRICE_W-1:0] p,
                                                  input logic [PRICE_W-1:0] x,
                                                  input logic               put);
        logic [PRICE_W-1:0] r;
        if (put) begin
            r = (x > p) ? x - p : '0;
        end else begin
            r = (p > x) ? p - x : '0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> sv/btop_dp.sv
// btop_dp: datapath of the binomial pricer, node memories and one shared multiplier
// depends on btop_pkg; driven by btop_ctrl commands
`default_nettype none

module btop_dp #(
    parameter int MAX_STEPS = 1024,
    parameter int AW        = $clog2(MAX_STEPS + 1)
) (
    input  wire logic                              aclk,
    input  wire btop_pkg::dp_cmd_t                 cmd,
    input  wire logic [AW-1:0]                     addr_v,
    input  wire logic [AW-1:0]                     addr_p,
    input  wire logic [AW-1:0]                     addr_w,
    input  wire logic [btop_pkg::PRICE_W-1:0]      spot,
    input  wire logic [btop_pkg::PRICE_W-1:0]      strike,
    input  wire logic [btop_pkg::FACTOR_W-1:0]     up_factor,
    input  wire logic [30:0]                       down_factor,
    input  wire logic [30:0]                       q,
    input  wire logic [30:0]                       nq,
    input  wire logic [30:0]                       disc,
    input  wire logic                              is_put,
    input  wire logic                              is_american,
    output logic      [btop_pkg::PRICE_W-1:0]      price,
    output logic                                   saturated
);

    localparam int PW = btop_pkg::PRICE_W;
    localparam int DEPTH = MAX_STEPS + 1;

    logic [PW-1:0] vmem [DEPTH];
    logic [PW-1:0] pmem [DEPTH];
    logic [PW-1:0] vq_reg, pq_reg;

    logic [PW-1:0] p_reg, x_reg, vlo_reg, vhi_reg, pr_reg, mix_reg, hold_reg;
    logic [PW-1:0] price_reg;
    logic          sat_reg, sat_next, sat_out_reg;
    logic [btop_pkg::PROD_W-1:0] prod_reg, acc_reg;

    logic [btop_pkg::FACTOR_W-1:0] ma, mb;
    logic [PW:0]   ps, mixs;
    logic [PW-1:0] ex, node_val;
    logic          v_we, p_we;
    logic [PW-1:0] v_wd, p_wd;

    // multiplier operand mux
    always_comb begin
        unique case (cmd.mul_sel)
            btop_pkg::MS_P_D:      begin ma = p_reg;        mb = {1'b0, down_factor}; end
            btop_pkg::MS_P_U:      begin ma = p_reg;        mb = up_factor;           end
            btop_pkg::MS_Q_VHI:    begin ma = {1'b0, q};    mb = vhi_reg;             end
            btop_pkg::MS_NQ_VLO:   begin ma = {1'b0, nq};   mb = vlo_reg;             end
            btop_pkg::MS_MIX_DISC: begin ma = mix_reg;      mb = {1'b0, disc};        end
            btop_pkg::MS_PR_U:     begin ma = pr_reg;       mb = up_factor;           end
            default:               begin ma = '0;           mb = '0;                  end
        endcase
    end

    // scaled product, mixed value, exercise and node result
    always_comb begin
        ps       = btop_pkg::sat_shift(prod_reg);
        mixs     = btop_pkg::sat_shift(acc_reg + prod_reg);
        ex       = btop_pkg::payoff(ps[PW-1:0], x_reg, is_put);
        node_val = (is_american && ex > hold_reg) ? ex : hold_reg;
        v_we     = cmd.leaf_wr | cmd.node_wr;
        p_we     = cmd.leaf_wr | (cmd.node_wr & is_american);
        v_wd     = cmd.leaf_wr ? btop_pkg::payoff(p_reg, x_reg, is_put) : node_val;
        p_wd     = cmd.leaf_wr ? p_reg : ps[PW-1:0];
    end

    // clip flag gathering
    always_comb begin
        sat_next = sat_reg;
        if (cmd.load) begin
            sat_next = 1'b0;
        end else begin
            if ((cmd.p_upd | cmd.hold_en | (cmd.node_wr & is_american)) && ps[PW]) begin
                sat_next = 1'b1;
            end
            if (cmd.mix_en && mixs[PW]) begin
                sat_next = 1'b1;
            end
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        sat_reg <= sat_next;
        if (cmd.mul_en) begin
            prod_reg <= btop_pkg::PROD_W'(ma) * btop_pkg::PROD_W'(mb);
        end
        if (cmd.acc_en)  acc_reg  <= prod_reg;
        if (cmd.mix_en)  mix_reg  <= mixs[PW-1:0];
        if (cmd.hold_en) hold_reg <= ps[PW-1:0];
        if (cmd.load) begin
            p_reg <= spot;
            x_reg <= strike;
        end else if (cmd.p_upd) begin
            p_reg <= ps[PW-1:0];
        end
        if (cmd.vlo_ld) begin
            vlo_reg <= vq_reg;
        end else if (cmd.node_wr) begin
            vlo_reg <= vhi_reg;
        end
        if (cmd.vhi_ld) begin
            vhi_reg <= vq_reg;
            pr_reg  <= pq_reg;
        end
        if (cmd.res_ld) begin
            price_reg   <= vq_reg;
            sat_out_reg <= sat_reg;
        end
    end

    // node value memory
    always_ff @(posedge aclk) begin
        if (v_we) vmem[addr_w] <= v_wd;
        vq_reg <= vmem[addr_v];
    end

    // node price memory
    always_ff @(posedge aclk) begin
        if (p_we) pmem[addr_w] <= p_wd;
        pq_reg <= pmem[addr_p];
    end

    assign price     = price_reg;
    assign saturated = sat_out_reg;

endmodule

`default_nettype wire

>>> sv/btop_ctrl.sv
// btop_ctrl: sequencer of the binomial pricer, walks leaves and tree levels
// depends on btop_pkg; drives btop_dp
`default_nettype none

module btop_ctrl #(
    parameter int MAX_STEPS = 1024,
    parameter int AW        = $clog2(MAX_STEPS + 1)
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  wire logic              m_ready,
    input  wire logic [AW-1:0]     n_steps,
    output btop_pkg::dp_cmd_t      cmd,
    output logic      [AW-1:0]     addr_v,
    output logic      [AW-1:0]     addr_p,
    output logic      [AW-1:0]     addr_w
);

    typedef enum logic [20:0] {
        ST_IDLE     = 21'h000001,
        ST_DOWN_MUL = 21'h000002,
        ST_DOWN_UPD = 21'h000004,
        ST_LEAF_WR  = 21'h000008,
        ST_LEAF_M1  = 21'h000010,
        ST_LEAF_U1  = 21'h000020,
        ST_LEAF_M2  = 21'h000040,
        ST_LEAF_U2  = 21'h000080,
        ST_LVL_RD   = 21'h000100,
        ST_LVL_LD   = 21'h000200,
        ST_N_RD     = 21'h000400,
        ST_N_LD     = 21'h000800,
        ST_N_M1     = 21'h001000,
        ST_N_M2     = 21'h002000,
        ST_N_MIX    = 21'h004000,
        ST_N_M3     = 21'h008000,
        ST_N_HOLD   = 21'h010000,
        ST_N_WR     = 21'h020000,
        ST_FIN_RD   = 21'h040000,
        ST_FIN_LD   = 21'h080000,
        ST_SPARE    = 21'h100000
    } state_t;

    state_t        state_reg, state_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic [AW-1:0] t_reg, t_next;
    logic [AW-1:0] j_reg, j_next;
    logic          mv_reg, mv_next;
    logic          out_free;

    assign out_free = !mv_reg || m_ready;

    // next state and command decode
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        t_next     = t_reg;
        j_next     = j_reg;
        mv_next    = mv_reg && !m_ready;
        cmd        = '0;
        cmd.mul_sel = btop_pkg::MS_P_D;
        addr_v     = '0;
        addr_p     = '0;
        addr_w     = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = (n_steps == '0) ? ST_LEAF_WR : ST_DOWN_MUL;
                end
            end
            ST_DOWN_MUL: begin
                cmd.mul_en = 1'b1;
                cmd.mul_sel = btop_pkg::MS_P_D;
                state_next = ST_DOWN_UPD;
            end
            ST_DOWN_UPD: begin
                cmd.p_upd = 1'b1;
                cnt_next  = cnt_reg + 1'b1;
                state_next = (cnt_reg + 1'b1 == n_steps) ? ST_LEAF_WR : ST_DOWN_MUL;
                if (cnt_reg + 1'b1 == n_steps) cnt_next = '0;
            end
            ST_LEAF_WR: begin
                cmd.leaf_wr = 1'b1;
                addr_w      = cnt_reg;
                if (cnt_reg == n_steps) begin
                    t_next     = n_steps;
                    j_next     = '0;
                    state_next = (n_steps == '0) ? ST_FIN_RD : ST_LVL_RD;
                end else begin
                    state_next = ST_LEAF_M1;
                end
            end
            ST_LEAF_M1: begin
                cmd.mul_en = 1'b1;
                cmd.mul_sel = btop_pkg::MS_P_U;
                state_next = ST_LEAF_U1;
            end
            ST_LEAF_U1: begin
                cmd.p_upd  = 1'b1;
                state_next = ST_LEAF_M2;
            end
            ST_LEAF_M2: begin
                cmd.mul_en = 1'b1;
                cmd.mul_sel = btop_pkg::MS_P_U;
                state_next = ST_LEAF_U2;
            end
            ST_LEAF_U2: begin
                cmd.p_upd  = 1'b1;
                cnt_next   = cnt_reg + 1'b1;
                state_next = ST_LEAF_WR;
            end
            ST_LVL_RD: begin
                addr_v     = '0;
                state_next = ST_LVL_LD;
            end
            ST_LVL_LD: begin
                cmd.vlo_ld = 1'b1;
                state_next = ST_N_RD;
            end
            ST_N_RD: begin
                addr_v     = j_reg + 1'b1;
                addr_p     = j_reg;
                state_next = ST_N_LD;
            end
            ST_N_LD: begin
                cmd.vhi_ld = 1'b1;
                state_next = ST_N_M1;
            end
            ST_N_M1: begin
                cmd.mul_en = 1'b1;
                cmd.mul_sel = btop_pkg::MS_Q_VHI;
                state_next = ST_N_M2;
            end
            ST_N_M2: begin
                cmd.acc_en = 1'b1;
                cmd.mul_en = 1'b1;
                cmd.mul_sel = btop_pkg::MS_NQ_VLO;
                state_next = ST_N_MIX;
            end
            ST_N_MIX: begin
                cmd.mix_en = 1'b1;
                state_next = ST_N_M3;
            end
            ST_N_M3: begin
                cmd.mul_en = 1'b1;
                cmd.mul_sel = btop_pkg::MS_MIX_DISC;
                state_next = ST_N_HOLD;
            end
            ST_N_HOLD: begin
                cmd.hold_en = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = btop_pkg::MS_PR_U;
                state_next  = ST_N_WR;
            end
            ST_N_WR: begin
                cmd.node_wr = 1'b1;
                addr_w      = j_reg;
                if (j_reg + 1'b1 == t_reg) begin
                    j_next = '0;
                    if (t_reg == AW'(1)) begin
                        state_next = ST_FIN_RD;
                    end else begin
                        t_next     = t_reg - 1'b1;
                        state_next = ST_LVL_RD;
                    end
                end else begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_N_RD;
                end
            end
            ST_FIN_RD: begin
                state_next = ST_FIN_LD;
            end
            ST_FIN_LD: begin
                if (out_free) begin
                    cmd.res_ld = 1'b1;
                    mv_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SPARE: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            t_reg     <= '0;
            j_reg     <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            t_reg     <= t_next;
            j_reg     <= j_next;
            mv_reg    <= mv_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = mv_reg;

    // node index stays inside the current level
    a_node_in_level: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_N_RD) |-> (j_reg < t_reg))
        else $error("node index beyond level");

    // down walk never runs past the step count
    a_down_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DOWN_MUL) |-> (cnt_reg < n_steps))
        else $error("down walk overran");

    // an accepted item starts work
    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg != ST_IDLE))
        else $error("item accepted but not started");

    // result capture raises valid
    a_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.res_ld |=> m_valid)
        else $error("result captured without valid");

    // no result is overwritten while waiting
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.res_ld && m_valid) |-> m_ready)
        else $error("pending result overwritten");

endmodule

`default_nettype wire

>>> sv/binomial_tree_option_pricer.sv
// binomial_tree_option_pricer: top level, APB register file plus controller and datapath
// depends on btop_pkg, btop_ctrl and btop_dp
//
// Usage: program the tree through the APB port (u, d, q, discount, steps,
// put/call, American/European) while the block is idle, then send items
// of (spot, strike) on the s_ channel. Each item yields one item on the m_
// channel: the root option value and a flag that is set when any
// intermediate value was clipped at the price maximum.
// The step count N is clamped to MAX_STEPS. Each tree node is paced by the
// single shared 32x32 multiplier and the one read port on each node memory;
// each tree level starts by loading its lowest node value, and a down walk
// and a leaf fill, each run step by step, come before the tree levels.
// One item is worked on at a time; s_ready is high
// only while idle. A finished result sits in an output register, so the
// next item is taken while it waits; if the receiver stalls, the following
// result holds in the datapath until the output register is free.
// Reset (aresetn low, synchronous) returns the configuration registers to their defaults,
// drops any item in flight and clears m_valid; node memories need no clearing.
`default_nettype none

module binomial_tree_option_pricer #(
    parameter int MAX_STEPS = 1024
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_spot,
    input  wire logic [31:0] s_strike,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic      [31:0] m_price,
    output logic             m_saturated
);

    localparam int AW = $clog2(MAX_STEPS + 1);

    logic [31:0] up_reg;
    logic [30:0] down_reg, prob_reg, disc_reg;
    logic [10:0] steps_reg;
    logic        put_reg, amer_reg;
    logic        wr_en;
    logic [2:0]  reg_idx;
    logic [AW-1:0] n_steps;
    logic [30:0] q, nq;

    btop_pkg::dp_cmd_t cmd;
    logic [AW-1:0] addr_v, addr_p, addr_w;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];
    assign pready  = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            up_reg    <= 32'h4000_0000;
            down_reg  <= 31'h4000_0000;
            prob_reg  <= 31'h2000_0000;
            disc_reg  <= 31'h4000_0000;
            steps_reg <= 11'd100;
            put_reg   <= 1'b0;
            amer_reg  <= 1'b0;
        end else if (wr_en) begin
            unique case (reg_idx)
                btop_pkg::REG_UP_FACTOR:   up_reg    <= pwdata;
                btop_pkg::REG_DOWN_FACTOR: down_reg  <= pwdata[30:0];
                btop_pkg::REG_UP_PROB:     prob_reg  <= pwdata[30:0];
                btop_pkg::REG_STEP_DISC:   disc_reg  <= pwdata[30:0];
                btop_pkg::REG_STEPS:       steps_reg <= pwdata[10:0];
                btop_pkg::REG_IS_PUT:      put_reg   <= pwdata[0];
                btop_pkg::REG_IS_AMERICAN: amer_reg  <= pwdata[0];
                default: ;
            endcase
        end
    end

    // register read-back
    always_comb begin
        unique case (reg_idx)
            btop_pkg::REG_UP_FACTOR:   prdata = up_reg;
            btop_pkg::REG_DOWN_FACTOR: prdata = {1'b0, down_reg};
            btop_pkg::REG_UP_PROB:     prdata = {1'b0, prob_reg};
            btop_pkg::REG_STEP_DISC:   prdata = {1'b0, disc_reg};
            btop_pkg::REG_STEPS:       prdata = {21'd0, steps_reg};
            btop_pkg::REG_IS_PUT:      prdata = {31'd0, put_reg};
            btop_pkg::REG_IS_AMERICAN: prdata = {31'd0, amer_reg};
            default:                   prdata = '0;
        endcase
    end

    // step count clamp and probability clamp
    always_comb begin
        n_steps = (32'(steps_reg) > 32'(MAX_STEPS)) ? AW'(MAX_STEPS) : AW'(steps_reg);
        q       = (prob_reg > btop_pkg::ONE_FACTOR) ? btop_pkg::ONE_FACTOR : prob_reg;
        nq      = btop_pkg::ONE_FACTOR - q;
    end

    btop_ctrl #(
        .MAX_STEPS (MAX_STEPS),
        .AW        (AW)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .n_steps (n_steps),
        .cmd     (cmd),
        .addr_v  (addr_v),
        .addr_p  (addr_p),
        .addr_w  (addr_w)
    );

    btop_dp #(
        .MAX_STEPS (MAX_STEPS),
        .AW        (AW)
    ) u_dp (
        .aclk        (aclk),
        .cmd         (cmd),
        .addr_v      (addr_v),
        .addr_p      (addr_p),
        .addr_w      (addr_w),
        .spot        (s_spot),
        .strike      (s_strike),
        .up_factor   (up_reg),
        .down_factor (down_reg),
        .q           (q),
        .nq          (nq),
        .disc        (disc_reg),
        .is_put      (put_reg),
        .is_american (amer_reg),
        .price       (m_price),
        .saturated   (m_saturated)
    );

endmodule

`default_nettype wire
